// ===== rtl/mtba_pkg.sv =====
// Shared types, codes and saturating arithmetic for the tangent basis accumulator.
package mtba_pkg;

	localparam int IDX_W     = 10;
	localparam int KIND_W    = 2;
	localparam int S_DATA_W  = 192;
	localparam int M_DATA_W  = 304;
	localparam int CFG_IDX_W = 1;
	localparam int MUL_STEPS = 20;
	localparam int RAW_CNT   = 10;

	typedef logic signed [31:0] q16_t;
	typedef logic signed [48:0] raw_t;
	typedef logic [IDX_W-1:0]   vidx_t;

	typedef struct packed {
		q16_t x;
		q16_t y;
		q16_t z;
	} vec3_t;

	typedef struct packed {
		raw_t x;
		raw_t y;
		raw_t z;
	} raw3_t;

	typedef struct packed {
		vec3_t pos;
		q16_t  u;
		q16_t  v;
	} vertex_t;

	typedef struct packed {
		vec3_t nrm;
		vec3_t tan;
		vec3_t btn;
	} accum_t;

	// Accumulate request toward the accumulator store.
	typedef struct packed {
		logic  en;
		logic  nrm_en;
		logic  tan_en;
		logic  btn_en;
		vec3_t nrm;
		vec3_t tan;
		vec3_t btn;
	} acc_add_t;

	// Status of the vector normalizer.
	typedef struct packed {
		logic  done;
		logic  nonzero;
		vec3_t unit;
	} norm_res_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD = 2'd0,
		KIND_TRI  = 2'd1,
		KIND_READ = 2'd2
	} kind_t;

	localparam logic [CFG_IDX_W-1:0] CFG_COMPUTE_NORMALS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPUTE_TANGENTS = 1'd1;

	// Product pair that yields the UV determinant.
	localparam logic [3:0] DET_PAIR = 4'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_OUT,
		ST_FETCH0,
		ST_FETCH1,
		ST_FETCH2,
		ST_FETCH3,
		ST_DELTA,
		ST_MUL,
		ST_TAN,
		ST_TAN_WAIT,
		ST_BTN,
		ST_BTN_WAIT,
		ST_ACC_ISSUE,
		ST_ACC_WAIT
	} state_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_MAX,
		N_SHIFT,
		N_SQ,
		N_SQRT,
		N_DIV,
		N_DONE
	} nstate_t;

	localparam q16_t Q16_MAX = 32'sh7fffffff;
	localparam q16_t Q16_MIN = 32'sh80000000;

	// Clamp a 49-bit value into the signed 32-bit range.
	function automatic q16_t sat_narrow(raw_t v);
		if (v[48:31] == {18{v[48]}}) begin
			return v[31:0];
		end
		return v[48] ? Q16_MIN : Q16_MAX;
	endfunction

	// Saturating addition.
	function automatic q16_t sat_add(q16_t a, q16_t b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			return s[32] ? Q16_MIN : Q16_MAX;
		end
		return s[31:0];
	endfunction

	// Saturating subtraction.
	function automatic q16_t sat_sub(q16_t a, q16_t b);
		logic signed [32:0] s;
		s = {a[31], a} - {b[31], b};
		if (s[32] != s[31]) begin
			return s[32] ? Q16_MIN : Q16_MAX;
		end
		return s[31:0];
	endfunction

endpackage

// ===== rtl/mtba_accum_store.sv =====
// Accumulator memory with clearing pass and saturating read-modify-write.
module mtba_accum_store #(
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	output logic                clear_busy,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output mtba_pkg::accum_t    rd_data,
	input  mtba_pkg::acc_add_t  add_req,
	input  logic [AW-1:0]       add_addr
);
	import mtba_pkg::*;

	accum_t    mem [DEPTH];
	accum_t    rdata_q;
	accum_t    sum;
	acc_add_t  req_s1;
	logic [AW-1:0] addr_s1;
	logic      pend_s1;
	logic [AW-1:0] clr_q;
	logic      clr_busy_q;

	function automatic vec3_t add3(vec3_t a, vec3_t b, logic en);
		vec3_t r;
		r.x = en ? sat_add(a.x, b.x) : a.x;
		r.y = en ? sat_add(a.y, b.y) : a.y;
		r.z = en ? sat_add(a.z, b.z) : a.z;
		return r;
	endfunction

	// Saturated sum of the entry read last cycle and the pending request.
	always_comb begin
		sum.nrm = add3(rdata_q.nrm, req_s1.nrm, req_s1.nrm_en);
		sum.tan = add3(rdata_q.tan, req_s1.tan, req_s1.tan_en);
		sum.btn = add3(rdata_q.btn, req_s1.btn, req_s1.btn_en);
	end

	// Clearing pass after reset and the write-back flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q      <= '0;
			pend_s1    <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == AW'(DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			pend_s1 <= add_req.en;
		end
	end

	// Request payload held for the write-back cycle.
	always_ff @(posedge clk) begin
		if (add_req.en) begin
			req_s1  <= add_req;
			addr_s1 <= add_addr;
		end
	end

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_q] <= '0;
		end else if (pend_s1) begin
			mem[addr_s1] <= sum;
		end
		if (rd_en || add_req.en) begin
			rdata_q <= mem[add_req.en ? add_addr : rd_addr];
		end
	end

	assign rd_data    = rdata_q;
	assign clear_busy = clr_busy_q;

	a_no_wb_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !clr_busy_q)
		else $error("accumulator write-back during clearing pass");

endmodule

// ===== rtl/mtba_unit_norm.sv =====
// Iterative unit-vector unit: scaling, sum of squares, square root and division.
module mtba_unit_norm (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  mtba_pkg::raw3_t      raw,
	input  logic                 flip,
	output mtba_pkg::norm_res_t  res
);
	import mtba_pkg::*;

	nstate_t      st_q, st_d;
	logic [47:0]  m_q [3];
	logic         neg_q [3];
	logic         flip_q;
	logic [47:0]  mx_q;
	logic [47:0]  mx_c;
	logic [61:0]  len2_q;
	logic [62:0]  r_q;
	logic [62:0]  bit_q;
	logic [32:0]  rem_q;
	logic [16:0]  q_q;
	logic [4:0]   dstep_q;
	logic [1:0]   j_q;
	logic [1:0]   j_next;
	q16_t         unit_q [3];
	logic         nz_q;
	raw_t         raw_a [3];
	logic [59:0]  sq;
	logic [63:0]  t;
	logic         ge_x;
	logic [30:0]  len;
	logic         ge_d;
	logic [16:0]  q_next;
	logic [32:0]  rem_sub;
	q16_t         qv;

	assign raw_a[0] = raw.x;
	assign raw_a[1] = raw.y;
	assign raw_a[2] = raw.z;

	// Datapath helpers for each phase.
	always_comb begin
		mx_c = m_q[0];
		if (m_q[1] > mx_c) mx_c = m_q[1];
		if (m_q[2] > mx_c) mx_c = m_q[2];
		sq      = m_q[j_q][29:0] * m_q[j_q][29:0];
		t       = {1'b0, r_q} + {1'b0, bit_q};
		ge_x    = {2'b00, len2_q} >= t;
		len     = r_q[30:0];
		ge_d    = rem_q >= {2'b00, len};
		q_next  = {q_q[15:0], ge_d};
		rem_sub = ge_d ? (rem_q - {2'b00, len}) : rem_q;
		qv      = {15'd0, q_next};
		j_next  = (j_q == 2'd2) ? 2'd0 : (j_q + 2'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= N_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			N_IDLE:  if (start) st_d = N_MAX;
			N_MAX:   st_d = (mx_c == '0) ? N_DONE : N_SHIFT;
			N_SHIFT: if (mx_q[47:30] == '0 && mx_q[29]) st_d = N_SQ;
			N_SQ:    if (j_q == 2'd2) st_d = N_SQRT;
			N_SQRT:  if (bit_q[0]) st_d = N_DIV;
			N_DIV:   if (dstep_q == 5'd16 && j_q == 2'd2) st_d = N_DONE;
			N_DONE:  st_d = N_IDLE;
			default: st_d = N_IDLE;
		endcase
	end

	// Working registers of each phase.
	always_ff @(posedge clk) begin
		case (st_q)
			N_IDLE: begin
				if (start) begin
					for (int k = 0; k < 3; k++) begin
						neg_q[k] <= raw_a[k][48];
						m_q[k]   <= raw_a[k][48] ? 48'(-raw_a[k]) : raw_a[k][47:0];
					end
					flip_q <= flip;
				end
			end
			N_MAX: begin
				mx_q <= mx_c;
				nz_q <= (mx_c != '0);
			end
			N_SHIFT: begin
				if (mx_q[47:30] != '0) begin
					for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
					mx_q <= mx_q >> 1;
				end else if (!mx_q[29]) begin
					for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 1;
					mx_q <= mx_q << 1;
				end else begin
					j_q    <= 2'd0;
					len2_q <= '0;
				end
			end
			N_SQ: begin
				len2_q <= len2_q + 62'(sq);
				j_q    <= j_next;
				if (j_q == 2'd2) begin
					r_q   <= '0;
					bit_q <= {1'b1, 62'd0};
				end
			end
			N_SQRT: begin
				// One result bit of the integer square root per cycle.
				if (ge_x) begin
					len2_q <= len2_q - t[61:0];
					r_q    <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					j_q     <= 2'd0;
					dstep_q <= '0;
					q_q     <= '0;
					rem_q   <= {3'd0, m_q[0][29:0]};
				end
			end
			N_DIV: begin
				// Restoring division, one quotient bit per cycle.
				q_q     <= q_next;
				rem_q   <= {rem_sub[31:0], 1'b0};
				dstep_q <= dstep_q + 5'd1;
				if (dstep_q == 5'd16) begin
					unit_q[j_q] <= (neg_q[j_q] ^ flip_q) ? -qv : qv;
					dstep_q     <= '0;
					q_q         <= '0;
					j_q         <= j_next;
					rem_q       <= {3'd0, m_q[j_next][29:0]};
				end
			end
			default: begin
			end
		endcase
	end

	assign res.done    = (st_q == N_DONE);
	assign res.nonzero = nz_q;
	assign res.unit    = {unit_q[0], unit_q[1], unit_q[2]};

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> st_q == N_IDLE)
		else $error("normalizer started while busy");

endmodule

// ===== rtl/mesh_tangent_basis_accumulator_unit.sv =====
// Top level: request decode, vertex memory, product sequencer and accumulate control.
// Accumulates per-vertex face normals and unit tangents and bitangents in Q16.16 with
// saturation. A load request writes a vertex. A read request returns the three
// accumulators of one vertex through the accumulator read register and the output register.
// A triangle request runs the three position and texture fetches from the vertex memory,
// twenty products through one shared 32x32 multiplier, then, with tangents on and a nonzero
// UV determinant, for each of tangent and bitangent a bit-serial square root and three
// bit-serial 17-step divisions, and finally a read-modify-write of the accumulator memory
// for each corner. After reset a clearing pass zeroes the accumulator memory, during which
// no request is taken; configuration writes are taken at any time.
module mesh_tangent_basis_accumulator_unit #(
	parameter int unsigned MAX_VERTICES = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// first_index, second_index, third_index, pos_x, pos_y, pos_z, tex_u, tex_v, zero pad
	input  logic [mtba_pkg::S_DATA_W-1:0]        s_axis_tdata,
	// kind
	input  logic [mtba_pkg::KIND_W-1:0]          s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// vertex_index, normal_x/y/z, tangent_x/y/z, bitangent_x/y/z, zero pad
	output logic [mtba_pkg::M_DATA_W-1:0]        m_axis_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mtba_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic                                 cfg_data
);
	import mtba_pkg::*;

	localparam int unsigned DEPTH = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t          state_q, state_d;
	logic            cn_q, ct_q;
	kind_t           in_kind;
	vidx_t           in_a, in_b, in_c;
	logic            a_ok, b_ok, c_ok;
	logic            accept;
	vertex_t         in_vtx;

	vertex_t         vmem [DEPTH];
	vertex_t         vrd_q;
	logic            vwr;
	logic            vrd_en;
	logic [AW-1:0]   vrd_addr;

	logic [AW-1:0]   i0_q, i1_q, i2_q;
	vidx_t           rd_idx_q;
	logic            rd_ok_q;
	vertex_t         v0_q, v1_q, v2_q;
	vec3_t           e1_q, e2_q;
	q16_t            du1_q, dv1_q, du2_q, dv2_q;

	logic [4:0]          mstep_q, pstep_q;
	logic                mvalid_q;
	q16_t                op_a, op_b;
	logic signed [63:0]  mprod;
	logic signed [63:0]  prod_q, first_q;
	logic signed [64:0]  diff_c;
	raw_t                res_q [RAW_CNT];
	logic                det_neg_q, det_zero_q;

	vec3_t           tan_q, btn_q;
	logic            tan_nz_q, btn_nz_q;
	logic [1:0]      corner_q;

	logic            norm_start;
	raw3_t           norm_raw;
	norm_res_t       nres;

	logic            clear_busy;
	logic            acc_rd_en;
	accum_t          acc_rd_data;
	acc_add_t        add_req;
	logic [AW-1:0]   add_addr;

	logic            out_valid_q;
	logic            out_load;
	vidx_t           out_idx_q;
	accum_t          out_acc_q;

	// Request decode.
	always_comb begin
		in_kind      = kind_t'(s_axis_tuser);
		in_a         = s_axis_tdata[9:0];
		in_b         = s_axis_tdata[19:10];
		in_c         = s_axis_tdata[29:20];
		in_vtx.pos.x = s_axis_tdata[61:30];
		in_vtx.pos.y = s_axis_tdata[93:62];
		in_vtx.pos.z = s_axis_tdata[125:94];
		in_vtx.u     = s_axis_tdata[157:126];
		in_vtx.v     = s_axis_tdata[189:158];
		a_ok         = 32'(in_a) < MAX_VERTICES;
		b_ok         = 32'(in_b) < MAX_VERTICES;
		c_ok         = 32'(in_c) < MAX_VERTICES;
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cn_q <= 1'b1;
			ct_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COMPUTE_NORMALS:  cn_q <= cfg_data;
				CFG_COMPUTE_TANGENTS: ct_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Vertex memory: loads write, triangle fetches read.
	assign vwr    = accept && (in_kind == KIND_LOAD) && a_ok;
	assign vrd_en = (state_q == ST_FETCH0) || (state_q == ST_FETCH1) ||
	                (state_q == ST_FETCH2);
	always_comb begin
		case (state_q)
			ST_FETCH0: vrd_addr = i0_q;
			ST_FETCH1: vrd_addr = i1_q;
			default:   vrd_addr = i2_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (vwr) begin
			vmem[in_a[AW-1:0]] <= in_vtx;
		end
		if (vrd_en) begin
			vrd_q <= vmem[vrd_addr];
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (!clear_busy) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					case (in_kind)
						KIND_TRI:  if (a_ok && b_ok && c_ok) state_d = ST_FETCH0;
						KIND_READ: state_d = ST_RD_OUT;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD_OUT:    if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			ST_FETCH0:    state_d = ST_FETCH1;
			ST_FETCH1:    state_d = ST_FETCH2;
			ST_FETCH2:    state_d = ST_FETCH3;
			ST_FETCH3:    state_d = ST_DELTA;
			ST_DELTA:     state_d = ST_MUL;
			ST_MUL:       if (mstep_q == 5'(MUL_STEPS)) state_d = ST_TAN;
			ST_TAN:       state_d = (ct_q && !det_zero_q) ? ST_TAN_WAIT : ST_ACC_ISSUE;
			ST_TAN_WAIT:  if (nres.done) state_d = ST_BTN;
			ST_BTN:       state_d = ST_BTN_WAIT;
			ST_BTN_WAIT:  if (nres.done) state_d = ST_ACC_ISSUE;
			ST_ACC_ISSUE: state_d = ST_ACC_WAIT;
			ST_ACC_WAIT:  state_d = (corner_q == 2'd2) ? ST_IDLE : ST_ACC_ISSUE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Operand selection for the shared multiplier, two products per difference.
	always_comb begin
		case (mstep_q)
			5'd0:    begin op_a = e1_q.y; op_b = e2_q.z; end
			5'd1:    begin op_a = e1_q.z; op_b = e2_q.y; end
			5'd2:    begin op_a = e1_q.z; op_b = e2_q.x; end
			5'd3:    begin op_a = e1_q.x; op_b = e2_q.z; end
			5'd4:    begin op_a = e1_q.x; op_b = e2_q.y; end
			5'd5:    begin op_a = e1_q.y; op_b = e2_q.x; end
			5'd6:    begin op_a = du1_q;  op_b = dv2_q;  end
			5'd7:    begin op_a = du2_q;  op_b = dv1_q;  end
			5'd8:    begin op_a = dv2_q;  op_b = e1_q.x; end
			5'd9:    begin op_a = dv1_q;  op_b = e2_q.x; end
			5'd10:   begin op_a = dv2_q;  op_b = e1_q.y; end
			5'd11:   begin op_a = dv1_q;  op_b = e2_q.y; end
			5'd12:   begin op_a = dv2_q;  op_b = e1_q.z; end
			5'd13:   begin op_a = dv1_q;  op_b = e2_q.z; end
			5'd14:   begin op_a = du1_q;  op_b = e2_q.x; end
			5'd15:   begin op_a = du2_q;  op_b = e1_q.x; end
			5'd16:   begin op_a = du1_q;  op_b = e2_q.y; end
			5'd17:   begin op_a = du2_q;  op_b = e1_q.y; end
			5'd18:   begin op_a = du1_q;  op_b = e2_q.z; end
			5'd19:   begin op_a = du2_q;  op_b = e1_q.z; end
			default: begin op_a = '0;     op_b = '0;     end
		endcase
	end

	assign mprod  = op_a * op_b;
	assign diff_c = {first_q[63], first_q} - {prod_q[63], prod_q};

	// Triangle datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			i0_q     <= in_a[AW-1:0];
			i1_q     <= in_b[AW-1:0];
			i2_q     <= in_c[AW-1:0];
			rd_idx_q <= in_a;
			rd_ok_q  <= a_ok;
		end
		case (state_q)
			ST_FETCH1: v0_q <= vrd_q;
			ST_FETCH2: v1_q <= vrd_q;
			ST_FETCH3: v2_q <= vrd_q;
			ST_DELTA: begin
				e1_q.x   <= sat_sub(v1_q.pos.x, v0_q.pos.x);
				e1_q.y   <= sat_sub(v1_q.pos.y, v0_q.pos.y);
				e1_q.z   <= sat_sub(v1_q.pos.z, v0_q.pos.z);
				e2_q.x   <= sat_sub(v2_q.pos.x, v0_q.pos.x);
				e2_q.y   <= sat_sub(v2_q.pos.y, v0_q.pos.y);
				e2_q.z   <= sat_sub(v2_q.pos.z, v0_q.pos.z);
				du1_q    <= sat_sub(v1_q.u, v0_q.u);
				dv1_q    <= sat_sub(v1_q.v, v0_q.v);
				du2_q    <= sat_sub(v2_q.u, v0_q.u);
				dv2_q    <= sat_sub(v2_q.v, v0_q.v);
				mstep_q  <= '0;
				mvalid_q <= 1'b0;
				corner_q <= 2'd0;
			end
			ST_MUL: begin
				if (mstep_q != 5'(MUL_STEPS)) begin
					prod_q   <= mprod;
					pstep_q  <= mstep_q;
					mvalid_q <= 1'b1;
					mstep_q  <= mstep_q + 5'd1;
				end else begin
					mvalid_q <= 1'b0;
				end
				// Exact difference of the pair, floored to Q16.16.
				if (mvalid_q) begin
					if (!pstep_q[0]) begin
						first_q <= prod_q;
					end else begin
						res_q[pstep_q[4:1]] <= diff_c[64:16];
						if (pstep_q[4:1] == DET_PAIR) begin
							det_neg_q  <= diff_c[64];
							det_zero_q <= (diff_c == '0);
						end
					end
				end
			end
			ST_TAN: begin
				tan_nz_q <= 1'b0;
				btn_nz_q <= 1'b0;
			end
			ST_TAN_WAIT: begin
				if (nres.done) begin
					tan_q    <= nres.unit;
					tan_nz_q <= nres.nonzero;
				end
			end
			ST_BTN_WAIT: begin
				if (nres.done) begin
					btn_q    <= nres.unit;
					btn_nz_q <= nres.nonzero;
				end
			end
			ST_ACC_WAIT: corner_q <= corner_q + 2'd1;
			default: begin
			end
		endcase
	end

	// Normalizer shared by tangent and bitangent.
	assign norm_start = ((state_q == ST_TAN) && ct_q && !det_zero_q) || (state_q == ST_BTN);
	assign norm_raw   = (state_q == ST_BTN) ? {res_q[7], res_q[8], res_q[9]}
	                                        : {res_q[4], res_q[5], res_q[6]};

	mtba_unit_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.raw    (norm_raw),
		.flip   (det_neg_q),
		.res    (nres)
	);

	// Accumulate request for the current corner.
	always_comb begin
		add_req.en     = (state_q == ST_ACC_ISSUE);
		add_req.nrm_en = cn_q;
		add_req.tan_en = tan_nz_q;
		add_req.btn_en = btn_nz_q;
		add_req.nrm.x  = sat_narrow(res_q[0]);
		add_req.nrm.y  = sat_narrow(res_q[1]);
		add_req.nrm.z  = sat_narrow(res_q[2]);
		add_req.tan    = tan_q;
		add_req.btn    = btn_q;
		case (corner_q)
			2'd0:    add_addr = i0_q;
			2'd1:    add_addr = i1_q;
			default: add_addr = i2_q;
		endcase
	end

	assign acc_rd_en = accept && (in_kind == KIND_READ) && a_ok;

	mtba_accum_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear_busy (clear_busy),
		.rd_en      (acc_rd_en),
		.rd_addr    (in_a[AW-1:0]),
		.rd_data    (acc_rd_data),
		.add_req    (add_req),
		.add_addr   (add_addr)
	);

	// Output register.
	assign out_load = (state_q == ST_RD_OUT) && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_idx_q <= rd_idx_q;
			out_acc_q <= rd_ok_q ? acc_rd_data : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0,
		out_acc_q.btn.z, out_acc_q.btn.y, out_acc_q.btn.x,
		out_acc_q.tan.z, out_acc_q.tan.y, out_acc_q.tan.x,
		out_acc_q.nrm.z, out_acc_q.nrm.y, out_acc_q.nrm.x,
		out_idx_q};

	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_RD_OUT)
		else $error("result shown without a read request");

	a_no_add_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		add_req.en |-> !clear_busy)
		else $error("accumulate issued during clearing pass");

	a_norm_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		nres.done |-> (state_q == ST_TAN_WAIT || state_q == ST_BTN_WAIT))
		else $error("normalizer finished outside a wait state");

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the mesh tangent basis accumulator: stimulus, prediction and checking.
`timescale 1ns / 1ps

module tb_top;
	import mtba_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int  NUM_VERTS   = 1024;
	localparam int  SETTLE      = 400;
	localparam longint CYCLE_LIMIT = 3000000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// first_index, second_index, third_index, pos_x, pos_y, pos_z, tex_u, tex_v, zero pad
	logic [S_DATA_W-1:0]   s_axis_tdata;
	// kind
	logic [KIND_W-1:0]     s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// vertex_index, normal_x/y/z, tangent_x/y/z, bitangent_x/y/z, zero pad
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic                  cfg_data;

	mesh_tangent_basis_accumulator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Tangent-space accumulation predictor and readback scoreboard.
	class tangent_scoreboard;
		int  pos_mem[NUM_VERTS][3];
		int  uv_mem[NUM_VERTS][2];
		int  nrm_sum[NUM_VERTS][3];
		int  tan_sum[NUM_VERTS][3];
		int  btn_sum[NUM_VERTS][3];
		bit  normals_on;
		bit  tangents_on;
		logic [M_DATA_W-1:0] readback_q[$];
		int  errors;
		int  reads_checked;
		int  triangles_seen;

		function void reset_state();
			foreach (nrm_sum[i, k]) begin
				nrm_sum[i][k] = 0;
				tan_sum[i][k] = 0;
				btn_sum[i][k] = 0;
			end
			normals_on  = 1'b1;
			tangents_on = 1'b1;
			errors = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic val);
			if (idx == CFG_COMPUTE_NORMALS) normals_on = val;
			else if (idx == CFG_COMPUTE_TANGENTS) tangents_on = val;
		endfunction

		function int sat32(longint x);
			if (x > 64'sd2147483647) return 32'h7fffffff;
			if (x < -64'sd2147483648) return 32'h80000000;
			return int'(x);
		endfunction

		// Exact a*b - c*d, floored to Q16.16.
		function longint cross_term(int a, int b, int c, int d);
			logic signed [65:0] pa, pb, r;
			pa = a;
			pa = pa * b;
			pb = c;
			pb = pb * d;
			r = (pa - pb) >>> 16;
			return r[63:0];
		endfunction

		function longint unsigned int_sqrt(longint unsigned x);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > x) b >>= 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		// Scale a raw vector to unit length; returns 0 for the zero vector.
		function bit unit_length(longint c[3], output int o[3]);
			longint unsigned m[3], mx, len2, len;
			bit neg[3];
			mx = 0;
			len2 = 0;
			for (int i = 0; i < 3; i++) begin
				neg[i] = c[i] < 0;
				m[i] = neg[i] ? -c[i] : c[i];
				if (m[i] > mx) mx = m[i];
				o[i] = 0;
			end
			if (mx == 0) return 1'b0;
			while (mx >= (64'd1 << 30)) begin
				for (int i = 0; i < 3; i++) m[i] >>= 1;
				mx >>= 1;
			end
			while (mx < (64'd1 << 29)) begin
				for (int i = 0; i < 3; i++) m[i] <<= 1;
				mx <<= 1;
			end
			for (int i = 0; i < 3; i++) len2 += m[i] * m[i];
			len = int_sqrt(len2);
			for (int i = 0; i < 3; i++) begin
				o[i] = int'((m[i] << 16) / len);
				if (neg[i]) o[i] = -o[i];
			end
			return 1'b1;
		endfunction

		function void add_to_corner(ref int acc[NUM_VERTS][3], int v, int a[3]);
			for (int k = 0; k < 3; k++) acc[v][k] = sat32(longint'(acc[v][k]) + a[k]);
		endfunction

		function void face_update(int i0, int i1, int i2);
			int e1[3], e2[3], add[3], du1, dv1, du2, dv2;
			longint raw[3], pa, pb;
			bit negdet;
			for (int k = 0; k < 3; k++) begin
				e1[k] = sat32(longint'(pos_mem[i1][k]) - pos_mem[i0][k]);
				e2[k] = sat32(longint'(pos_mem[i2][k]) - pos_mem[i0][k]);
			end
			if (normals_on) begin
				add[0] = sat32(cross_term(e1[1], e2[2], e1[2], e2[1]));
				add[1] = sat32(cross_term(e1[2], e2[0], e1[0], e2[2]));
				add[2] = sat32(cross_term(e1[0], e2[1], e1[1], e2[0]));
				add_to_corner(nrm_sum, i0, add);
				add_to_corner(nrm_sum, i1, add);
				add_to_corner(nrm_sum, i2, add);
			end
			if (!tangents_on) return;
			du1 = sat32(longint'(uv_mem[i1][0]) - uv_mem[i0][0]);
			dv1 = sat32(longint'(uv_mem[i1][1]) - uv_mem[i0][1]);
			du2 = sat32(longint'(uv_mem[i2][0]) - uv_mem[i0][0]);
			dv2 = sat32(longint'(uv_mem[i2][1]) - uv_mem[i0][1]);
			pa = longint'(du1) * dv2;
			pb = longint'(du2) * dv1;
			// A degenerate UV mapping contributes no tangent frame.
			if (pa == pb) return;
			negdet = pa < pb;
			for (int k = 0; k < 3; k++) raw[k] = cross_term(dv2, e1[k], dv1, e2[k]);
			if (unit_length(raw, add)) begin
				if (negdet) for (int k = 0; k < 3; k++) add[k] = -add[k];
				add_to_corner(tan_sum, i0, add);
				add_to_corner(tan_sum, i1, add);
				add_to_corner(tan_sum, i2, add);
			end
			for (int k = 0; k < 3; k++) raw[k] = cross_term(du1, e2[k], du2, e1[k]);
			if (unit_length(raw, add)) begin
				if (negdet) for (int k = 0; k < 3; k++) add[k] = -add[k];
				add_to_corner(btn_sum, i0, add);
				add_to_corner(btn_sum, i1, add);
				add_to_corner(btn_sum, i2, add);
			end
		endfunction

		// Update the predicted state for one accepted request.
		function void note_request(logic [KIND_W-1:0] kind, logic [S_DATA_W-1:0] d);
			int a, b, c;
			logic [M_DATA_W-1:0] r;
			a = d[9:0];
			b = d[19:10];
			c = d[29:20];
			if (kind == KIND_LOAD) begin
				for (int k = 0; k < 3; k++) pos_mem[a][k] = d[30 + 32*k +: 32];
				uv_mem[a][0] = d[126 +: 32];
				uv_mem[a][1] = d[158 +: 32];
			end else if (kind == KIND_TRI) begin
				triangles_seen++;
				face_update(a, b, c);
			end else if (kind == KIND_READ) begin
				r = '0;
				r[9:0] = a;
				for (int k = 0; k < 3; k++) begin
					r[10 + 32*k +: 32]  = nrm_sum[a][k];
					r[106 + 32*k +: 32] = tan_sum[a][k];
					r[202 + 32*k +: 32] = btn_sum[a][k];
				end
				readback_q = {readback_q, r};
			end
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH @%0t: %s", $realtime, msg);
		endtask

		// Compare one readback with the oldest prediction.
		task check_readback(logic [M_DATA_W-1:0] got);
			logic [M_DATA_W-1:0] want;
			string names[10];
			names = '{"vertex_index", "normal_x", "normal_y", "normal_z", "tangent_x",
				"tangent_y", "tangent_z", "bitangent_x", "bitangent_y", "bitangent_z"};
			if (readback_q.size() == 0) begin
				report($sformatf("unexpected readback of vertex %0d", got[9:0]));
				return;
			end
			want = readback_q.pop_front();
			reads_checked++;
			if (got[9:0] !== want[9:0])
				report($sformatf("%s got %0d want %0d", names[0], got[9:0], want[9:0]));
			for (int f = 0; f < 9; f++) begin
				if (got[10 + 32*f +: 32] !== want[10 + 32*f +: 32])
					report($sformatf("vertex %0d %s got %h want %h", want[9:0], names[f + 1],
						got[10 + 32*f +: 32], want[10 + 32*f +: 32]));
			end
		endtask
	endclass

	tangent_scoreboard sb;
	bit    rx_no_stall;
	bit    tx_no_gap;
	bit    loaded[NUM_VERTS];
	int    loaded_list[$];
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run-length guard.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: random stalls, accept and check readbacks.
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = rx_no_stall ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			sb.check_readback(m_axis_tdata);
		end
	end

	// Drive one request, honoring a random gap before it.
	task send_request(logic [KIND_W-1:0] kind, int a, int b, int c,
			int px, int py, int pz, int u, int v);
		int gap;
		gap = tx_no_gap ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = kind;
		s_axis_tdata  = {2'b00, v, u, pz, py, px, c[9:0], b[9:0], a[9:0]};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(kind, s_axis_tdata);
		if (kind == KIND_LOAD && !loaded[a]) begin
			loaded[a] = 1'b1;
			loaded_list = {loaded_list, a};
		end
		@(negedge clk);
	endtask

	task load_vertex(int a, int px, int py, int pz, int u, int v);
		send_request(KIND_LOAD, a, 0, 0, px, py, pz, u, v);
	endtask

	task send_triangle(int a, int b, int c);
		send_request(KIND_TRI, a, b, c, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task read_vertex(int a);
		send_request(KIND_READ, a, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
	endtask

	// Wait until every readback is in and any trailing triangle has retired.
	task drain();
		s_axis_tvalid = 1'b0;
		while (sb.readback_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task write_register(logic [CFG_IDX_W-1:0] idx, logic val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_register(idx, val);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Q16.16 value: a mix of extremes, small, medium and full-range numbers.
	function int pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 2) == 0 ? 32'h7fffffff :
				($urandom_range(0, 1) ? 32'h80000000 : 0);
			1, 2: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
			3: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
			default: return $urandom;
		endcase
	endfunction

	function int pick_loaded();
		return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
	endfunction

	task random_phase(int count);
		int sel, a, b, c;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				tx_no_gap   = $urandom_range(0, 3) == 0;
				rx_no_stall = $urandom_range(0, 3) == 0;
			end
			sel = $urandom_range(0, 99);
			if (sel < 35) begin
				a = $urandom_range(0, 9) < 7 ? $urandom_range(0, 31) : $urandom_range(0, 1023);
				load_vertex(a, pick_value(), pick_value(), pick_value(), pick_value(),
					pick_value());
			end else if (sel < 70) begin
				a = pick_loaded();
				b = pick_loaded();
				c = $urandom_range(0, 9) == 0 ? a : pick_loaded();
				send_triangle(a, b, c);
			end else if (sel < 97) begin
				read_vertex($urandom_range(0, 9) < 7 ? pick_loaded() : $urandom_range(0, 1023));
			end else begin
				send_request(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom);
			end
		end
	endtask

	// Main sequence.
	initial begin
		int one;
		bit cfg_n[5], cfg_t[5];
		sb = new();
		sb.reset_state();
		one = 32'h00010000;
		cfg_n = '{1, 0, 1, 0, 1};
		cfg_t = '{1, 1, 0, 0, 1};
		rx_no_stall = 1'b0;
		tx_no_gap = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = KIND_LOAD;
		cfg_valid = 1'b0;
		cfg_index = CFG_COMPUTE_NORMALS;
		cfg_data = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: unit triangle, saturating corners, degenerate UVs, repeated corners.
		load_vertex(0, 0, 0, 0, 0, 0);
		load_vertex(1, one, 0, 0, one, 0);
		load_vertex(2, 0, one, 0, 0, one);
		send_triangle(0, 1, 2);
		read_vertex(0);
		read_vertex(1);
		read_vertex(2);
		load_vertex(3, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		load_vertex(4, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		load_vertex(5, 32'h7fffffff, 32'h80000000, 0, 32'h12345678, 32'h87654321);
		send_triangle(3, 4, 5);
		send_triangle(4, 3, 5);
		send_triangle(0, 1, 1);
		send_triangle(0, 1, 3);
		load_vertex(6, 0, 0, one, 2 * one, 0);
		send_triangle(0, 1, 6);
		send_request(KIND_UNUSED, 7, 8, 9, 1, 2, 3, 4, 5);
		read_vertex(1023);
		for (int i = 3; i <= 6; i++) read_vertex(i);
		drain();

		// Random phases across every register setting.
		for (int p = 0; p < 5; p++) begin
			write_register(CFG_COMPUTE_NORMALS, cfg_n[p]);
			write_register(CFG_COMPUTE_TANGENTS, cfg_t[p]);
			random_phase(200);
			drain();
		end

		$display("Covered %0d triangles and %0d readbacks over five register settings.",
			sb.triangles_seen, sb.reads_checked);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
